// File: rtl/core/etf_pkg.sv
// ----------------------------------------------------------------------------
// etf_pkg
// Shared types and constants for the escape-time fractal pixel block.
// ----------------------------------------------------------------------------
package etf_pkg;

  localparam int FRAC_BITS = 28;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_CLAMP,
    ST_INIT,
    ST_SQ,
    ST_TEST,
    ST_UPD,
    ST_DIV,
    ST_PAL,
    ST_OUT
  } etf_state_t;

  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_MAXIT   = 3'd1;
  localparam logic [2:0] REG_XSTART  = 3'd2;
  localparam logic [2:0] REG_YSTART  = 3'd3;
  localparam logic [2:0] REG_XSTEP   = 3'd4;
  localparam logic [2:0] REG_YSTEP   = 3'd5;
  localparam logic [2:0] REG_JRE     = 3'd6;
  localparam logic [2:0] REG_JIM     = 3'd7;

  localparam int PAL_STEPS = 8;

  typedef struct packed {
    logic map;
    logic clamp;
    logic init;
    logic sq;
    logic upd;
    logic div_start;
    logic div_step;
    logic pal_step;
    logic out_load;
  } etf_cmd_t;

  typedef struct packed {
    logic esc_big;
    logic esc_mag;
    logic iter_done;
    logic div_done;
    logic pal_done;
  } etf_status_t;

endpackage

// File: rtl/core/escape_time_fractal_pixel.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel
// Mandelbrot / Julia escape-time iteration with polynomial palette.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | pixel_col, pixel_row
// out     | output    | out_valid/out_stall| iter_count, inside_set, rgb
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// each item passes map, clamp and init, then square, test and update for each
// iteration (an escape on |z|^2 is found in test), then DW = ITER_WIDTH+17
// steps of the restoring divider, the palette steps and the output hand-off.
// one item at a time.
// reset clears the controller, output valid and loads register defaults.
// a stalled result holds the block at its final state until it is taken.
module escape_time_fractal_pixel #(
  parameter int COORD_WIDTH = 32,
  parameter int ITER_WIDTH  = 10,
  parameter int INDEX_WIDTH = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [INDEX_WIDTH-1:0] in_pixel_col,
  input  logic [INDEX_WIDTH-1:0] in_pixel_row,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [ITER_WIDTH-1:0]  out_iter_count,
  output logic                   out_inside_set,
  output logic [7:0]             out_red,
  output logic [7:0]             out_green,
  output logic [7:0]             out_blue,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data
);
  import etf_pkg::*;

  logic mode_r;
  logic [ITER_WIDTH-1:0] max_iter_r;
  logic signed [COORD_WIDTH-1:0] xs_r, ys_r, xd_r, yd_r, jr_r, ji_r;
  etf_cmd_t cmd;
  etf_status_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      max_iter_r <= ITER_WIDTH'(128);
      xs_r <= '0; ys_r <= '0; xd_r <= '0; yd_r <= '0;
      jr_r <= COORD_WIDTH'(-64'sd200093238);
      ji_r <= COORD_WIDTH'(64'sd30334898);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:   mode_r <= cfg_data[0];
        REG_MAXIT:  max_iter_r <= cfg_data[ITER_WIDTH-1:0];
        REG_XSTART: xs_r <= cfg_data;
        REG_YSTART: ys_r <= cfg_data;
        REG_XSTEP:  xd_r <= cfg_data;
        REG_YSTEP:  yd_r <= cfg_data;
        REG_JRE:    jr_r <= cfg_data;
        REG_JIM:    ji_r <= cfg_data;
        default: ;
      endcase
    end
  end

  etf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_busy(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  etf_dp #(
    .COORD_WIDTH(COORD_WIDTH), .ITER_WIDTH(ITER_WIDTH), .INDEX_WIDTH(INDEX_WIDTH)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_pixel_col(in_pixel_col), .in_pixel_row(in_pixel_row),
    .mode(mode_r), .max_iter(max_iter_r),
    .x_start(xs_r), .y_start(ys_r), .x_step(xd_r), .y_step(yd_r),
    .julia_re(jr_r), .julia_im(ji_r),
    .out_stall(out_stall), .out_valid(out_valid),
    .out_iter_count(out_iter_count), .out_inside_set(out_inside_set),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue)
  );
endmodule

// File: rtl/core/etf_ctrl.sv
// ----------------------------------------------------------------------------
// etf_ctrl
// Sequencer: mapping, iteration loop, division, palette steps and output hand-off.
// ----------------------------------------------------------------------------
module etf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 out_busy,
  input  logic                 out_stall,
  input  etf_pkg::etf_status_t sts,
  output etf_pkg::etf_cmd_t    cmd
);
  import etf_pkg::*;

  etf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_MAP;
      ST_MAP:   state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_INIT;
      ST_INIT:  state_nxt = ST_SQ;
      ST_SQ: begin
        if (sts.iter_done || sts.esc_big) state_nxt = ST_DIV;
        else state_nxt = ST_TEST;
      end
      ST_TEST:  state_nxt = sts.esc_mag ? ST_DIV : ST_UPD;
      ST_UPD:   state_nxt = ST_SQ;
      ST_DIV:   if (sts.div_done) state_nxt = ST_PAL;
      ST_PAL:   if (sts.pal_done) state_nxt = ST_OUT;
      ST_OUT:   if (!out_busy || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:  cmd.map = in_valid;
      ST_MAP:   cmd.clamp = 1'b1;
      ST_CLAMP: cmd.init = 1'b1;
      ST_INIT:  cmd.sq = 1'b1;
      ST_SQ: begin
        if (sts.iter_done || sts.esc_big) cmd.div_start = 1'b1;
      end
      ST_TEST: begin
        if (sts.esc_mag) cmd.div_start = 1'b1;
        else cmd.upd = 1'b1;
      end
      ST_UPD:   cmd.sq = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_PAL:   cmd.pal_step = 1'b1;
      ST_OUT:   cmd.out_load = !out_busy || !out_stall;
      default:  cmd = '0;
    endcase
  end
endmodule

// File: rtl/core/etf_dp.sv
// ----------------------------------------------------------------------------
// etf_dp
// Datapath: coordinate map, complex square step, divider, palette and output.
// ----------------------------------------------------------------------------
module etf_dp #(
  parameter int COORD_WIDTH = 32,
  parameter int ITER_WIDTH  = 10,
  parameter int INDEX_WIDTH = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  etf_pkg::etf_cmd_t             cmd,
  output etf_pkg::etf_status_t          sts,
  input  logic [INDEX_WIDTH-1:0]        in_pixel_col,
  input  logic [INDEX_WIDTH-1:0]        in_pixel_row,
  input  logic                          mode,
  input  logic [ITER_WIDTH-1:0]         max_iter,
  input  logic signed [COORD_WIDTH-1:0] x_start,
  input  logic signed [COORD_WIDTH-1:0] y_start,
  input  logic signed [COORD_WIDTH-1:0] x_step,
  input  logic signed [COORD_WIDTH-1:0] y_step,
  input  logic signed [COORD_WIDTH-1:0] julia_re,
  input  logic signed [COORD_WIDTH-1:0] julia_im,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [ITER_WIDTH-1:0]         out_iter_count,
  output logic                          out_inside_set,
  output logic [7:0]                    out_red,
  output logic [7:0]                    out_green,
  output logic [7:0]                    out_blue
);
  import etf_pkg::*;

  // product width, never narrower than the clamp limit needs
  localparam int PW = (COORD_WIDTH + INDEX_WIDTH + 1 > 52) ?
                      COORD_WIDTH + INDEX_WIDTH + 1 : 52;
  localparam int ZW = FRAC_BITS + 4;
  localparam int SW = 2 * ZW;
  localparam int DW = ITER_WIDTH + 17;
  localparam int DCW = $clog2(DW + 1);

  localparam logic signed [PW-1:0] PLIM = PW'(64'sd1 << 50);
  localparam logic signed [PW+1:0] CLIM = (PW+2)'(64'sd4 <<< FRAC_BITS);
  localparam logic signed [ZW-1:0] ZLIM = ZW'(64'sd4 <<< FRAC_BITS);
  localparam logic signed [ZW+1:0] TWO  = (ZW+2)'(64'sd2 <<< FRAC_BITS);
  localparam logic [SW:0]          FOUR2 = (SW+1)'(64'd4) << (2 * FRAC_BITS);

  logic signed [PW-1:0] prx_r, pry_r;
  logic signed [ZW-1:0] px_r, py_r, zr_r, zi_r, cr_r, ci_r;
  logic [SW-1:0]        rr_r, ii_r;
  logic signed [SW-1:0] ri_r;
  logic [ITER_WIDTH-1:0] k_r;

  function automatic logic signed [PW-1:0] clp(input logic signed [PW:0] v);
    if (v > PW'(PLIM)) return PLIM;
    if (v < -$signed({1'b0, PLIM})) return -PLIM;
    return v[PW-1:0];
  endfunction

  function automatic logic signed [ZW-1:0] clz(input logic signed [PW+1:0] v);
    if (v > CLIM) return ZLIM;
    if (v < -CLIM) return -ZLIM;
    return v[ZW-1:0];
  endfunction

  logic signed [PW:0] mx, my;
  assign mx = (PW+1)'(x_step * $signed({1'b0, in_pixel_col}));
  assign my = (PW+1)'(y_step * $signed({1'b0, in_pixel_row}));

  logic signed [ZW+1:0] zr_x, zi_x;
  assign zr_x = (ZW+2)'(zr_r);
  assign zi_x = (ZW+2)'(zi_r);

  logic signed [SW:0] d_rr_ii;
  logic signed [ZW+1:0] zr_n, zi_n;
  assign d_rr_ii = $signed({1'b0, rr_r}) - $signed({1'b0, ii_r});
  assign zr_n = (ZW+2)'(d_rr_ii >>> FRAC_BITS) + (ZW+2)'(cr_r);
  assign zi_n = (ZW+2)'(ri_r >>> (FRAC_BITS - 1)) + (ZW+2)'(ci_r);

  assign sts.esc_big = zr_x > TWO || zr_x < -TWO || zi_x > TWO || zi_x < -TWO;
  assign sts.esc_mag = ({1'b0, rr_r} + {1'b0, ii_r}) > FOUR2;
  assign sts.iter_done = (k_r == max_iter);

  always_ff @(posedge clk) begin
    if (cmd.map) begin
      prx_r <= clp(mx);
      pry_r <= clp(my);
    end
    if (cmd.clamp) begin
      px_r <= clz((PW+2)'(x_start) + (PW+2)'(prx_r));
      py_r <= clz((PW+2)'(y_start) + (PW+2)'(pry_r));
    end
    if (cmd.init) begin
      k_r <= '0;
      if (mode) begin
        zr_r <= px_r; zi_r <= py_r;
        cr_r <= ZW'(julia_re); ci_r <= ZW'(julia_im);
      end else begin
        zr_r <= '0; zi_r <= '0;
        cr_r <= px_r; ci_r <= py_r;
      end
    end
    if (cmd.sq) begin
      rr_r <= SW'(zr_r * zr_r);
      ii_r <= SW'(zi_r * zi_r);
      ri_r <= SW'(zr_r * zi_r);
    end
    if (cmd.upd) begin
      zr_r <= zr_n[ZW-1:0];
      zi_r <= zi_n[ZW-1:0];
      k_r <= k_r + 1'b1;
    end
  end

  // restoring division for t = k*65536/max_iter
  logic [DW-1:0] rem_r, quo_r;
  logic [DCW-1:0] dcnt_r;
  logic [DW:0] trial;
  assign trial = {rem_r, quo_r[DW-1]} - (DW+1)'(max_iter);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r  <= '0;
      quo_r  <= DW'({k_r, 16'd0});
      dcnt_r <= DCW'(DW);
    end else if (cmd.div_step && dcnt_r != 0) begin
      dcnt_r <= dcnt_r - 1'b1;
      if (!trial[DW]) begin
        rem_r <= trial[DW-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DW-2:0], quo_r[DW-1]};
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end
    end
  end
  assign sts.div_done = (dcnt_r == 0);

  // palette: one 17x17 multiply per step
  logic [16:0] t_r, u_r, pr_r, pa_r, pb_r, pg_r, pbl_r;
  logic [3:0]  pcnt_r;
  logic [16:0] ma, mb;
  logic [33:0] mp;
  assign mp = ma * mb;

  always_comb begin
    ma = t_r; mb = t_r;
    case (pcnt_r)
      4'd1: begin ma = pr_r;  mb = t_r; end
      4'd2: begin ma = pr_r;  mb = u_r; end
      4'd3: begin ma = u_r;   mb = u_r; end
      4'd4: begin ma = pa_r;  mb = pb_r; end
      4'd5: begin ma = pb_r;  mb = u_r; end
      4'd6: begin ma = pbl_r; mb = t_r; end
      default: begin ma = t_r; mb = t_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!cmd.pal_step) begin
      pcnt_r <= '0;
      t_r <= quo_r[16:0];
      u_r <= 17'd65536 - quo_r[16:0];
    end else if (pcnt_r != 4'(PAL_STEPS)) begin
      pcnt_r <= pcnt_r + 1'b1;
      case (pcnt_r)
        4'd0: begin pr_r <= mp[32:16]; pa_r <= mp[32:16]; end
        4'd1: pr_r <= mp[32:16];
        4'd2: pr_r <= mp[32:16];
        4'd3: pb_r <= mp[32:16];
        4'd4: pg_r <= mp[32:16];
        4'd5: pbl_r <= mp[32:16];
        4'd6: pbl_r <= mp[32:16];
        default: ;
      endcase
    end
  end
  assign sts.pal_done = (pcnt_r == 4'(PAL_STEPS));

  logic [29:0] cr_m, cg_m, cb_m;
  assign cr_m = 30'(pr_r) * 30'd2295;
  assign cg_m = 30'(pg_r) * 30'd3825;
  assign cb_m = 30'(pbl_r) * 30'd4335;

  logic ins;
  assign ins = (k_r == max_iter);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_iter_count <= k_r;
      out_inside_set <= ins;
      out_red   <= ins ? 8'd0 : cr_m[23:16];
      out_green <= ins ? 8'd0 : cg_m[23:16];
      out_blue  <= ins ? 8'd0 : cb_m[24:17];
    end
  end
endmodule

// File: rtl/core/etf_checker.sv
// ----------------------------------------------------------------------------
// etf_checker
// Port-level checks for the escape-time fractal pixel block.
// ----------------------------------------------------------------------------
module etf_checker #(
  parameter int ITER_WIDTH = 10
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [ITER_WIDTH-1:0] out_iter_count,
  input logic                  out_inside_set,
  input logic [7:0]            out_red,
  input logic [7:0]            out_green,
  input logic [7:0]            out_blue
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_iter_count))
    else $error("stalled item changed");
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_set |-> out_red == 0 && out_green == 0 && out_blue == 0)
    else $error("inside item not black");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted second item while busy");
  a_noout: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too early");
endmodule

bind escape_time_fractal_pixel etf_checker #(.ITER_WIDTH(ITER_WIDTH)) u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_iter_count(out_iter_count),
  .out_inside_set(out_inside_set), .out_red(out_red), .out_green(out_green),
  .out_blue(out_blue)
);
